// ===== rtl/core/ryge_pkg.sv =====
// Shared types, register codes and constant arithmetic for the RGB-to-YJK group encoder.
// No dependencies; ryge_lane, the top level and the testbench import this package.
package ryge_pkg;

  // Cycles from a lane's input to its registered luma output.
  localparam int LANE_LAT = 29;

  typedef enum logic {
    REG_DITHER = 1'b0,
    REG_MONO   = 1'b1
  } reg_idx_t;

  // Per-pixel operands handed from the group stage to a luma lane.
  typedef struct packed {
    logic        [7:0] r;
    logic        [7:0] g;
    logic        [7:0] b;
    logic        [7:0] bright;
    logic signed [9:0] j;
    logic signed [9:0] k;
    logic        [2:0] dth;
    logic              dith;
  } lane_in_t;

  // 4x4 ordered dither; columns repeat with period two.
  function automatic logic [2:0] dither_val(input logic [1:0] row, input logic [1:0] col);
    logic [2:0] v;
    case (row)
      2'd0:    v = col[0] ? 3'd4 : 3'd0;
      2'd1:    v = col[0] ? 3'd2 : 3'd6;
      2'd2:    v = col[0] ? 3'd5 : 3'd1;
      default: v = col[0] ? 3'd3 : 3'd7;
    endcase
    return v;
  endfunction

  // Exact floor division by constants through reciprocal multiply.
  function automatic logic [21:0] div5(input logic [23:0] x);
    logic [48:0] p;
    p = 49'(x) * 49'd26843546;
    return p[48:27];
  endfunction

  function automatic logic [9:0] div29(input logic [13:0] x);
    logic [28:0] p;
    p = 29'(x) * 29'd18079;
    return p[28:19];
  endfunction

  function automatic logic [11:0] div511(input logic [19:0] x);
    logic [40:0] p;
    p = 41'(x) * 41'd1050629;
    return p[40:29];
  endfunction

endpackage

// ===== rtl/core/ryge_delay.sv =====
// Enabled shift line that carries side data alongside a pipelined unit.
// No dependencies.
module ryge_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q = pipe_r[DEPTH-1];

endmodule

// ===== rtl/core/ryge_udiv.sv =====
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// No dependencies; the caller guarantees the quotient fits in QW bits.
module ryge_udiv #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 13
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW-1];
  logic [QW-1:0] low_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] quo_r [QW];
  logic [NW-1:0] num_hi;

  assign num_hi = num >> QW;

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in = num_hi[DW-1:0];
      assign low_in = num[QW-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign low_in = low_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    if (s < QW - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[s] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
          low_r[s] <= low_in << 1;
          den_r[s] <= den_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_r[s] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// ===== rtl/core/ryge_lane.sv =====
// One pixel's luma path: weight dividers, weighted sum, sum divider, dither blend, clamp.
// Depends on ryge_pkg, ryge_udiv and ryge_delay.
module ryge_lane import ryge_pkg::*; (
  input  logic     clk,
  input  logic     adv,
  input  lane_in_t li,
  output logic [4:0] luma
);

  typedef struct packed {
    logic signed [11:0] a4;
    logic signed [9:0]  rj;
    logic signed [9:0]  gk;
    logic signed [10:0] y0;
    logic        [8:0]  mix;
    logic        [2:0]  dth;
    logic               dith;
    logic               bz;
  } sb1_t;

  typedef struct packed {
    logic               neg;
    logic signed [10:0] y0;
    logic        [8:0]  mix;
    logic        [2:0]  dth;
    logic               dith;
  } sb2_t;

  // Entry: side operands, including the fallback estimate y0.
  logic        [10:0] base;
  logic signed [15:0] j16, k16, s_y;
  logic        [13:0] s_mag;
  logic        [9:0]  q29;
  logic signed [10:0] q29s;
  logic        [9:0]  bg, mixw;
  logic signed [12:0] a4w;
  logic signed [10:0] rjw, gkw;
  sb1_t sb1_in, sb1_out;

  always_comb begin
    base   = {3'b0, li.b} + {2'b0, li.r, 1'b0} + {1'b0, li.g, 2'b0};
    j16    = 16'(li.j);
    k16    = 16'(li.k);
    s_y    = $signed({3'b0, base, 2'b0}) - (j16 * 16'sd6) - (k16 * 16'sd15);
    s_mag  = s_y[15] ? 14'(-s_y) : s_y[13:0];
    q29    = div29(s_mag);
    q29s   = $signed({1'b0, q29});
    bg     = ({2'b0, li.b} + {2'b0, li.g}) >> 1;
    mixw   = {2'b0, li.r} + 10'd255 - bg;
    a4w    = $signed({3'b0, li.b, 2'b0}) + 13'(li.j) + 13'(li.j) + 13'(li.k);
    rjw    = $signed({3'b0, li.r}) - 11'(li.j);
    gkw    = $signed({3'b0, li.g}) - 11'(li.k);
    sb1_in.a4   = a4w[11:0];
    sb1_in.rj   = rjw[9:0];
    sb1_in.gk   = gkw[9:0];
    sb1_in.y0   = s_y[15] ? -q29s : q29s;
    sb1_in.mix  = mixw[8:0];
    sb1_in.dth  = li.dth;
    sb1_in.dith = li.dith;
    sb1_in.bz   = (li.bright == 8'd0);
  end

  logic [12:0] qr, qg, qb;

  ryge_udiv #(.NW(16), .DW(8), .QW(13)) u_div_r (
    .clk(clk), .adv(adv), .num({li.r, 8'b0}), .den(li.bright), .quo(qr)
  );
  ryge_udiv #(.NW(16), .DW(8), .QW(13)) u_div_g (
    .clk(clk), .adv(adv), .num({li.g, 8'b0}), .den(li.bright), .quo(qg)
  );
  ryge_udiv #(.NW(16), .DW(8), .QW(13)) u_div_b (
    .clk(clk), .adv(adv), .num({li.b, 8'b0}), .den(li.bright), .quo(qb)
  );
  ryge_delay #(.W($bits(sb1_t)), .DEPTH(13)) u_sb1 (
    .clk(clk), .adv(adv), .d(sb1_in), .q(sb1_out)
  );

  // Products stage.
  logic        [12:0] wr, wg, wb;
  logic signed [25:0] pb_r;
  logic signed [23:0] pr_r, pg_r;
  logic        [14:0] wsum_r;
  logic signed [10:0] y0_p_r;
  logic        [8:0]  mix_p_r;
  logic        [2:0]  dth_p_r;
  logic               dith_p_r;

  assign wr = sb1_out.bz ? 13'd256 : qr;
  assign wg = sb1_out.bz ? 13'd256 : qg;
  assign wb = sb1_out.bz ? 13'd256 : qb;

  always_ff @(posedge clk) begin
    if (adv) begin
      pb_r     <= sb1_out.a4 * $signed({1'b0, wb});
      pr_r     <= sb1_out.rj * $signed({1'b0, wr});
      pg_r     <= sb1_out.gk * $signed({1'b0, wg});
      wsum_r   <= {2'b0, wr} + {2'b0, wg} + {2'b0, wb};
      y0_p_r   <= sb1_out.y0;
      mix_p_r  <= sb1_out.mix;
      dth_p_r  <= sb1_out.dth;
      dith_p_r <= sb1_out.dith;
    end
  end

  // Divide the blue term by five, truncating toward zero.
  logic        [23:0] pb_mag;
  logic signed [22:0] q5s, q5_nxt;
  logic signed [22:0] q5_r;
  logic signed [23:0] pr_q_r, pg_q_r;
  logic        [14:0] wsum_q_r;
  logic signed [10:0] y0_q_r;
  logic        [8:0]  mix_q_r;
  logic        [2:0]  dth_q_r;
  logic               dith_q_r;

  assign pb_mag = pb_r[25] ? 24'(-pb_r) : pb_r[23:0];
  assign q5s    = $signed({1'b0, div5(pb_mag)});
  assign q5_nxt = pb_r[25] ? -q5s : q5s;

  always_ff @(posedge clk) begin
    if (adv) begin
      q5_r     <= q5_nxt;
      pr_q_r   <= pr_r;
      pg_q_r   <= pg_r;
      wsum_q_r <= wsum_r;
      y0_q_r   <= y0_p_r;
      mix_q_r  <= mix_p_r;
      dth_q_r  <= dth_p_r;
      dith_q_r <= dith_p_r;
    end
  end

  // Sum the numerator, split into sign and magnitude for the divider.
  logic signed [26:0] nsum;
  logic        [24:0] nmag_r;
  logic        [14:0] wsum_s_r;
  sb2_t sb2_r, sb2_out;

  assign nsum = 27'(q5_r) + 27'(pr_q_r) + 27'(pg_q_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      nmag_r        <= nsum[26] ? 25'(-nsum) : nsum[24:0];
      wsum_s_r      <= wsum_q_r;
      sb2_r.neg     <= nsum[26];
      sb2_r.y0      <= y0_q_r;
      sb2_r.mix     <= mix_q_r;
      sb2_r.dth     <= dth_q_r;
      sb2_r.dith    <= dith_q_r;
    end
  end

  logic [9:0] qv;

  ryge_udiv #(.NW(25), .DW(15), .QW(10)) u_div_v (
    .clk(clk), .adv(adv), .num(nmag_r), .den(wsum_s_r), .quo(qv)
  );
  ryge_delay #(.W($bits(sb2_t)), .DEPTH(10)) u_sb2 (
    .clk(clk), .adv(adv), .d(sb2_r), .q(sb2_out)
  );

  // Blend: (v - y0) * mix.
  logic signed [10:0] qvs, v_nxt;
  logic signed [11:0] diff;
  logic signed [21:0] t_r;
  logic signed [10:0] v_t_r, y0_t_r;
  logic        [2:0]  dth_t_r;
  logic               dith_t_r;

  assign qvs   = $signed({1'b0, qv});
  assign v_nxt = sb2_out.neg ? -qvs : qvs;
  assign diff  = 12'(v_nxt) - 12'(sb2_out.y0);

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r      <= diff * $signed({1'b0, sb2_out.mix});
      v_t_r    <= v_nxt;
      y0_t_r   <= sb2_out.y0;
      dth_t_r  <= sb2_out.dth;
      dith_t_r <= sb2_out.dith;
    end
  end

  // Divide the blend by 511, truncating toward zero.
  logic        [19:0] t_mag;
  logic signed [12:0] q511s;
  logic signed [12:0] q511_r;
  logic signed [10:0] v_u_r, y0_u_r;
  logic        [2:0]  dth_u_r;
  logic               dith_u_r;

  assign t_mag = t_r[21] ? 20'(-t_r) : t_r[19:0];
  assign q511s = $signed({1'b0, div511(t_mag)});

  always_ff @(posedge clk) begin
    if (adv) begin
      q511_r   <= t_r[21] ? -q511s : q511s;
      v_u_r    <= v_t_r;
      y0_u_r   <= y0_t_r;
      dth_u_r  <= dth_t_r;
      dith_u_r <= dith_t_r;
    end
  end

  // Final estimate, scale by 1/8 and clamp to 0..31.
  logic signed [13:0] vv;
  logic        [4:0]  luma_r;

  assign vv = dith_u_r ? (14'(q511_r) + 14'(y0_u_r) + $signed({11'b0, dth_u_r}))
                       : 14'(v_u_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (vv[13]) begin
        luma_r <= 5'd0;
      end else if (vv >= 14'sd256) begin
        luma_r <= 5'd31;
      end else begin
        luma_r <= vv[7:3];
      end
    end
  end

  assign luma = luma_r;

endmodule

// ===== rtl/core/rgb_to_yjk_group_encoder_top.sv =====
// Top level of the RGB-to-YJK group encoder: group stages, four luma lanes, output register.
// Depends on ryge_pkg, ryge_lane and ryge_delay.
//
// Takes one group of four RGB pixels per beat and returns four packed bytes per beat, one
// group per clock sustained while out_ready stays high. The pipeline is two group stages
// (split, then sums and shared chroma J/K), the luma lane (a 13-stage divider for the
// brightness weights and a 10-stage divider for the weighted average make up most of it),
// and the output register. The whole pipeline holds as one while the output beat waits, so
// no beat is lost or repeated, and in_ready follows out_ready whenever a result is waiting.
// Registers: dither_enable at byte address 0 and mono_mode at 4, bit 0 each; write them only
// while the pipeline is empty. In mono mode each byte is the blue channel, plus dither if
// enabled, masked with 0xF8.
module rgb_to_yjk_group_encoder_top import ryge_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_pixel_zero,
  input  logic [23:0] in_pixel_one,
  input  logic [23:0] in_pixel_two,
  input  logic [23:0] in_pixel_three,
  input  logic [1:0]  in_row_phase,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_zero,
  output logic [7:0]  out_byte_one,
  output logic [7:0]  out_byte_two,
  output logic [7:0]  out_byte_three,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef struct packed {
    logic        mono;
    logic [31:0] monob;
    logic [5:0]  kb;
    logic [5:0]  jb;
  } side_t;

  // Signed division by four, truncating toward zero.
  function automatic logic signed [9:0] sdiv4(input logic signed [10:0] x);
    logic [10:0] m;
    logic [9:0]  q;
    m = x[10] ? 11'(-x) : x;
    q = {2'b0, m[9:2]};
    return x[10] ? -$signed(q) : $signed(q);
  endfunction

  // Configuration port.
  logic dither_en_r, mono_en_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dither_en_r <= 1'b0;
      mono_en_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_DITHER: dither_en_r <= pwdata[0];
        REG_MONO:   mono_en_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_DITHER: prdata = {31'b0, dither_en_r};
      REG_MONO:   prdata = {31'b0, mono_en_r};
      default:    prdata = '0;
    endcase
  end

  // Advance every stage together; hold all of them while the output beat waits.
  logic out_valid_r;
  logic adv;

  assign adv      = ~out_valid_r | out_ready;
  assign in_ready = adv;

  // Stage A: split channels, pick dither, brightness and luma terms per pixel.
  logic [23:0] pix [4];
  logic        va_r;
  logic [7:0]  ra_r [4], ga_r [4], ba_r [4], bra_r [4], yta_r [4], monob_a_r [4];
  logic [2:0]  dtha_r [4];
  logic        dith_a_r, mono_a_r;

  assign pix[0] = in_pixel_zero;
  assign pix[1] = in_pixel_one;
  assign pix[2] = in_pixel_two;
  assign pix[3] = in_pixel_three;

  for (genvar i = 0; i < 4; i++) begin : g_split
    logic [7:0]  r, g, b, sum_bd;
    logic [2:0]  dth;
    logic [16:0] bw;

    assign r      = pix[i][23:16];
    assign g      = pix[i][15:8];
    assign b      = pix[i][7:0];
    assign dth    = dither_en_r ? dither_val(in_row_phase, 2'(i)) : 3'd0;
    assign bw     = 17'(g) * 17'd153 + 17'(r) * 17'd76 + 17'(b) * 17'd27;
    assign sum_bd = b + {5'b0, dth};

    always_ff @(posedge clk) begin
      if (adv) begin
        ra_r[i]      <= r;
        ga_r[i]      <= g;
        ba_r[i]      <= b;
        dtha_r[i]    <= dth;
        bra_r[i]     <= bw[15:8];
        yta_r[i]     <= {1'b0, b[7:1]} + {2'b0, r[7:2]} + {3'b0, g[7:3]} + {5'b0, dth};
        // drop the carry of the dither add, as the mask does
        monob_a_r[i] <= sum_bd & 8'hF8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dith_a_r <= dither_en_r;
      mono_a_r <= mono_en_r;
    end
  end

  // Stage B: group sums and shared chroma.
  logic [9:0]         yy, sr, sg;
  logic signed [10:0] dj, dk;
  logic signed [9:0]  j_nxt, k_nxt;
  logic               vb_r;
  lane_in_t           lin_r [4];
  side_t              side_b_r, side_out;

  always_comb begin
    yy = '0;
    sr = '0;
    sg = '0;
    for (int i = 0; i < 4; i++) begin
      yy = yy + {2'b0, yta_r[i]};
      sr = sr + {2'b0, ra_r[i]};
      sg = sg + {2'b0, ga_r[i]};
    end
    dj    = $signed({1'b0, sr}) - $signed({1'b0, yy});
    dk    = $signed({1'b0, sg}) - $signed({1'b0, yy});
    j_nxt = sdiv4(dj);
    k_nxt = sdiv4(dk);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        lin_r[i].r      <= ra_r[i];
        lin_r[i].g      <= ga_r[i];
        lin_r[i].b      <= ba_r[i];
        lin_r[i].bright <= bra_r[i];
        lin_r[i].j      <= j_nxt;
        lin_r[i].k      <= k_nxt;
        lin_r[i].dth    <= dtha_r[i];
        lin_r[i].dith   <= dith_a_r;
      end
      side_b_r.mono  <= mono_a_r;
      side_b_r.monob <= {monob_a_r[3], monob_a_r[2], monob_a_r[1], monob_a_r[0]};
      side_b_r.kb    <= k_nxt[8:3];
      side_b_r.jb    <= j_nxt[8:3];
    end
  end

  // Luma lanes, with chroma and mono bytes carried alongside.
  logic [4:0] luma [4];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    ryge_lane u_lane (
      .clk(clk), .adv(adv), .li(lin_r[i]), .luma(luma[i])
    );
  end

  ryge_delay #(.W($bits(side_t)), .DEPTH(LANE_LAT)) u_side (
    .clk(clk), .adv(adv), .d(side_b_r), .q(side_out)
  );

  logic [LANE_LAT-1:0] vpipe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r <= '0;
    end else if (adv) begin
      vpipe_r <= {vpipe_r[LANE_LAT-2:0], vb_r};
    end
  end

  // Output register: pack luma with chroma slices, or pass the mono bytes.
  logic [7:0] ob_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vpipe_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side_out.mono) begin
        ob_r[0] <= side_out.monob[7:0];
        ob_r[1] <= side_out.monob[15:8];
        ob_r[2] <= side_out.monob[23:16];
        ob_r[3] <= side_out.monob[31:24];
      end else begin
        ob_r[0] <= {luma[0], side_out.kb[2:0]};
        ob_r[1] <= {luma[1], side_out.kb[5:3]};
        ob_r[2] <= {luma[2], side_out.jb[2:0]};
        ob_r[3] <= {luma[3], side_out.jb[5:3]};
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_zero  = ob_r[0];
  assign out_byte_one   = ob_r[1];
  assign out_byte_two   = ob_r[2];
  assign out_byte_three = ob_r[3];

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid_r)
    else $error("output valid right after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> va_r)
    else $error("accepted beat missing from first stage");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vpipe_r) && $stable(vb_r) && $stable(va_r))
    else $error("pipeline moved while held");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vpipe_r[LANE_LAT-1] |=> out_valid_r)
    else $error("lane result dropped at output register");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rgb_to_yjk_group_encoder_top: directed and random pixel groups
// over every dither/mono setting, with idle gaps on both sides. Needs ryge_pkg and the RTL.
module testbench;
  import ryge_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [23:0] in_pixel_zero, in_pixel_one, in_pixel_two, in_pixel_three;
  logic [1:0]  in_row_phase;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte_zero, out_byte_one, out_byte_two, out_byte_three;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } packed_bytes_t;

  // Model copy of the two registers.
  logic          dither_on;
  logic          mono_on;
  packed_bytes_t byte_queue[$];
  int            mismatches;
  // Sink mode: 0 random stalls, 1 always ready.
  bit            sink_steady;
  bit            src_steady;

  rgb_to_yjk_group_encoder_top u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_pixel_zero, .in_pixel_one, .in_pixel_two,
    .in_pixel_three, .in_row_phase, .out_valid, .out_ready, .out_byte_zero, .out_byte_one,
    .out_byte_two, .out_byte_three, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Ordered dither pattern, column repeats every two pixels.
  function automatic int dither_at(input int row, input int col);
    int pat[4][2];
    pat = '{'{0, 4}, '{6, 2}, '{1, 5}, '{7, 3}};
    return pat[row][col % 2];
  endfunction

  // Brightness-normalized luma estimate; all divisions truncate toward zero.
  function automatic int weighted_luma(input int r, input int g, input int b,
                                       input int j, input int k);
    int bright, wr, wg, wb, wsum;
    bright = (g * 153 + r * 76 + b * 27) / 256;
    wr = (bright != 0) ? (r * 256) / bright : 256;
    wg = (bright != 0) ? (g * 256) / bright : 256;
    wb = (bright != 0) ? (b * 256) / bright : 256;
    wsum = wr + wg + wb;
    if (wsum == 0) return 255;
    return ((b * 4 + j * 2 + k) * wb / 5 + (r - j) * wr + (g - k) * wg) / wsum;
  endfunction

  function automatic packed_bytes_t encode_group(input logic [23:0] px[4], input int row);
    int r[4], g[4], b[4], d[4], luma[4];
    int yy, j, k, v, y0, mix;
    logic [7:0] res[4];
    yy = 0; j = 0; k = 0;
    for (int i = 0; i < 4; i++) begin
      b[i] = px[i][7:0];
      g[i] = px[i][15:8];
      r[i] = px[i][23:16];
      d[i] = dither_on ? dither_at(row, i) : 0;
    end
    if (mono_on) begin
      // Carry out of bit 7 is dropped by the 8-bit mask.
      for (int i = 0; i < 4; i++) res[i] = 8'(b[i] + d[i]) & 8'hF8;
      return {res[0], res[1], res[2], res[3]};
    end
    for (int i = 0; i < 4; i++) begin
      yy += b[i] / 2 + r[i] / 4 + g[i] / 8 + d[i];
      j += r[i];
      k += g[i];
    end
    j = (j - yy) / 4;
    k = (k - yy) / 4;
    for (int i = 0; i < 4; i++) begin
      v = weighted_luma(r[i], g[i], b[i], j, k);
      if (dither_on) begin
        y0 = ((b[i] + r[i] * 2 + g[i] * 4) * 4 - 6 * j - 15 * k) / 29;
        mix = r[i] - (b[i] + g[i]) / 2 + 255;
        v = (v - y0) * mix / 511 + y0 + d[i];
      end
      v /= 8;
      if (v < 0) v = 0;
      if (v > 31) v = 31;
      luma[i] = v;
    end
    // Chroma slices come from the two's complement bits of J and K.
    res[0] = {luma[0][4:0], k[5:3]};
    res[1] = {luma[1][4:0], k[8:6]};
    res[2] = {luma[2][4:0], j[5:3]};
    res[3] = {luma[3][4:0], j[8:6]};
    return {res[0], res[1], res[2], res[3]};
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return 0;
    if (sel < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one group, hold it until the beat is taken, then log the expected bytes.
  task automatic send_group(input logic [23:0] p0, input logic [23:0] p1,
                            input logic [23:0] p2, input logic [23:0] p3, input int row);
    logic [23:0] px[4];
    int gap;
    px = '{p0, p1, p2, p3};
    in_valid       = 1'b1;
    in_pixel_zero  = p0;
    in_pixel_one   = p1;
    in_pixel_two   = p2;
    in_pixel_three = p3;
    in_row_phase   = 2'(row);
    do @(posedge clk); while (!in_ready);
    byte_queue.push_back(encode_group(px, row));
    @(negedge clk);
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drain the pipeline; a register write is only safe with nothing in flight.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (byte_queue.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = 3'(int'(idx) * 4);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_mode(input logic dith, input logic mono);
    wait_drained();
    // Upper bits must be ignored; only bit 0 counts.
    write_reg(REG_DITHER, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0, dith});
    write_reg(REG_MONO, {31'd0, mono});
    dither_on = dith;
    mono_on   = mono;
  endtask

  function automatic logic [23:0] rand_pixel();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 24'h000000 | 24'($urandom_range(0, 7));
      1: return 24'hFFFFFF ^ 24'($urandom_range(0, 7));
      2: return {8'($urandom), 16'd0};
      3: return {8'd0, 8'd0, 8'($urandom)};
      4: return {8'd0, 8'($urandom), 8'd0};
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    for (int row = 0; row < 4; row++)
      send_group(24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h0000FF, row);
    send_group(24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF, 0);  // negative J and K
    send_group(24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000, 1);  // large J
    send_group(24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00, 2);  // large K
    send_group(24'h000001, 24'h000100, 24'h010000, 24'h000000, 3);  // dark pixels
    send_group(24'hAAAAAA, 24'h555555, 24'hFFFFFF, 24'h000000, 1);
  endtask

  task automatic test_dither();
    for (int row = 0; row < 4; row++)
      send_group(24'h808080, 24'hFF00FF, 24'h00FFFF, 24'h102030, row);
    send_group(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 3);
    send_group(24'h000000, 24'h000000, 24'h000000, 24'h000000, 3);
  endtask

  task automatic test_mono();
    for (int row = 0; row < 4; row++)
      // Blue near the top wraps past 255 when dither is added.
      send_group(24'h0000FF, 24'h0000FC, 24'hFFFFF8, 24'h000007, row);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      // Alternate steady and bursty stretches on the source.
      if (n % 64 == 0) src_steady = ($urandom_range(0, 3) == 0);
      // Hold off once until the pipeline has fully drained.
      if (n == count / 2) while (byte_queue.size() != 0) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
      send_group(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel(), $urandom_range(0, 3));
    end
    src_steady = 1'b0;
  endtask

  // Result sink: random stalls with occasional always-ready stretches.
  initial begin
    int hold;
    out_ready   = 1'b0;
    sink_steady = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) sink_steady = ~sink_steady;
      if (sink_steady) out_ready = 1'b1;
      else begin
        hold = pick_gap();
        if (hold > 0) begin
          out_ready = 1'b0;
          repeat (hold - 1) @(negedge clk);
        end else out_ready = 1'b1;
      end
    end
  end

  // Compare each output beat against the oldest expectation.
  always @(posedge clk) begin
    packed_bytes_t want;
    if (rst_n && out_valid && out_ready) begin
      if (byte_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h %h %h %h",
          out_byte_zero, out_byte_one, out_byte_two, out_byte_three);
      end else begin
        want = byte_queue.pop_front();
        if (want !== {out_byte_zero, out_byte_one, out_byte_two, out_byte_three}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %h, got %h %h %h %h",
              want.b0, want.b1, want.b2, want.b3,
              out_byte_zero, out_byte_one, out_byte_two, out_byte_three);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_zero = '0; in_pixel_one = '0; in_pixel_two = '0; in_pixel_three = '0;
    in_row_phase = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    dither_on = 1'b0; mono_on = 1'b0;
    mismatches = 0;
    src_steady = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_extremes();            // reset settings: color, no dither
    set_mode(1'b1, 1'b0);
    test_dither();
    test_extremes();
    set_mode(1'b0, 1'b1);
    test_mono();
    set_mode(1'b1, 1'b1);
    test_mono();
    set_mode(1'b0, 1'b0);
    test_random(300);
    set_mode(1'b1, 1'b0);
    test_random(300);
    set_mode(1'b0, 1'b1);
    test_random(150);
    set_mode(1'b1, 1'b1);
    test_random(150);
    set_mode(1'($urandom_range(0, 1)), 1'b0);
    test_random(150);

    wait_drained();
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
